>>> rtl/core/eos_pkg.sv
// Shared types, constants and helpers for the Exif orientation scanner.
package eos_pkg;

  // One byte beat of the marker payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } eos_item_t;

  // One result beat
  typedef struct packed {
    logic        found;
    logic [15:0] orientation;
    logic        in_range;
  } eos_result_t;

  localparam logic [7:0]  ORDER_II    = 8'h49;
  localparam logic [7:0]  ORDER_MM    = 8'h4D;
  localparam logic [31:0] TIFF_MAGIC  = 32'h0000_002A;
  localparam logic [31:0] IFD_OFFSET  = 32'h0000_0008;
  localparam logic [31:0] TAG_ORIENT  = 32'h0000_0112;
  localparam logic [31:0] TYPE_SHORT  = 32'h0000_0003;
  localparam logic [31:0] COUNT_ONE   = 32'h0000_0001;
  localparam logic [15:0] ORIENT_MIN  = 16'd1;
  localparam logic [15:0] ORIENT_MAX  = 16'd8;

  // Expected identifier "Exif" 0 0, by byte position
  function automatic logic [7:0] ident_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h45;
      3'd1:    val = 8'h78;
      3'd2:    val = 8'h69;
      3'd3:    val = 8'h66;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Add byte b as byte k of a multi-byte field in the given byte order
  function automatic logic [31:0] gather(input logic [31:0] acc_in, input logic [7:0] b,
                                         input logic [1:0] k, input logic be);
    logic [31:0] base;
    base = (k == 2'd0) ? 32'd0 : acc_in;
    if (be) begin
      return {base[23:0], b};
    end
    return base | ({24'd0, b} << {k, 3'b000});
  endfunction

endpackage

>>> rtl/core/eos_in_reg.sv
// Input register: captures one byte beat and holds it until the scanner takes it.
module eos_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                advance,
  output logic                item_valid,
  output eos_pkg::eos_item_t  item
);

  assign byte_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!byte_stall) begin
      item_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      item.data_byte <= data_byte;
      item.last_byte <= last_byte;
    end
  end

endmodule

>>> rtl/core/eos_scan.sv
// Header check and IFD entry scan: per-byte state update and result decision.
module eos_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  eos_pkg::eos_item_t    item,
  output logic                  res_valid,
  output eos_pkg::eos_result_t  res
);

  typedef enum logic [2:0] {
    PH_IDENT  = 3'd0,
    PH_ORDER  = 3'd1,
    PH_MAGIC  = 3'd2,
    PH_OFFSET = 3'd3,
    PH_COUNT  = 3'd4,
    PH_ENTRY  = 3'd5,
    PH_VALUE  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    OC_NONE  = 2'd0,
    OC_MISS  = 2'd1,
    OC_FOUND = 2'd2
  } outcome_t;

  phase_t      phase, phase_next;
  logic [3:0]  pos, pos_next;
  logic        big_endian, big_endian_next;
  logic [7:0]  first_order_byte, first_order_byte_next;
  logic [15:0] tags_left, tags_left_next;
  logic [31:0] acc, acc_next;
  logic        entry_matches, entry_matches_next;
  logic        decided;

  outcome_t    outcome, outcome_fin;
  logic [31:0] acc_g;
  logic [3:0]  entry_k;
  logic [15:0] value;
  logic [7:0]  b;

  assign b = item.data_byte;

  // Field byte index inside the entry: tag, type, count
  always_comb begin
    if (pos < 4'd2) begin
      entry_k = pos;
    end else if (pos < 4'd4) begin
      entry_k = pos - 4'd2;
    end else begin
      entry_k = pos - 4'd4;
    end
  end

  always_comb begin
    phase_next            = phase;
    pos_next              = pos;
    big_endian_next       = big_endian;
    first_order_byte_next = first_order_byte;
    tags_left_next        = tags_left;
    acc_next              = acc;
    entry_matches_next    = entry_matches;
    outcome               = OC_NONE;
    acc_g                 = 32'd0;
    unique case (phase)
      PH_IDENT: begin
        if (pos > 4'd5 || b != eos_pkg::ident_byte(pos[2:0])) begin
          outcome = OC_MISS;
        end else if (pos == 4'd5) begin
          phase_next = PH_ORDER;
          pos_next   = 4'd0;
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      PH_ORDER: begin
        if (pos == 4'd0) begin
          first_order_byte_next = b;
          pos_next              = 4'd1;
        end else if (first_order_byte == eos_pkg::ORDER_II && b == eos_pkg::ORDER_II) begin
          big_endian_next = 1'b0;
          phase_next      = PH_MAGIC;
          pos_next        = 4'd0;
        end else if (first_order_byte == eos_pkg::ORDER_MM && b == eos_pkg::ORDER_MM) begin
          big_endian_next = 1'b1;
          phase_next      = PH_MAGIC;
          pos_next        = 4'd0;
        end else begin
          outcome = OC_MISS;
        end
      end
      PH_MAGIC: begin
        acc_g    = eos_pkg::gather(acc, b, pos[1:0], big_endian);
        acc_next = acc_g;
        if (pos >= 4'd1) begin
          if (acc_g != eos_pkg::TIFF_MAGIC) begin
            outcome = OC_MISS;
          end else begin
            phase_next = PH_OFFSET;
            pos_next   = 4'd0;
          end
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      PH_OFFSET: begin
        acc_g    = eos_pkg::gather(acc, b, pos[1:0], big_endian);
        acc_next = acc_g;
        if (pos >= 4'd3) begin
          if (acc_g != eos_pkg::IFD_OFFSET) begin
            outcome = OC_MISS;
          end else begin
            phase_next = PH_COUNT;
            pos_next   = 4'd0;
          end
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      PH_COUNT: begin
        acc_g    = eos_pkg::gather(acc, b, pos[1:0], big_endian);
        acc_next = acc_g;
        if (pos >= 4'd1) begin
          tags_left_next = acc_g[15:0];
          if (acc_g[15:0] == 16'd0) begin
            outcome = OC_MISS;
          end else begin
            phase_next = PH_ENTRY;
            pos_next   = 4'd0;
          end
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      PH_ENTRY: begin
        acc_g = eos_pkg::gather(acc, b, entry_k[1:0], big_endian);
        if (pos < 4'd8) begin
          acc_next = acc_g;
        end
        if (pos == 4'd1) begin
          entry_matches_next = (acc_g == eos_pkg::TAG_ORIENT);
        end else if (pos == 4'd3) begin
          entry_matches_next = entry_matches && (acc_g == eos_pkg::TYPE_SHORT);
        end else if (pos == 4'd7) begin
          entry_matches_next = entry_matches && (acc_g == eos_pkg::COUNT_ONE);
        end
        if (pos == 4'd7 && entry_matches && acc_g == eos_pkg::COUNT_ONE) begin
          phase_next = PH_VALUE;
          pos_next   = 4'd0;
        end else if (pos >= 4'd11) begin
          // entry done: count it off, miss when none are left
          tags_left_next = tags_left - 16'd1;
          pos_next       = 4'd0;
          if (tags_left == 16'd1) begin
            outcome = OC_MISS;
          end
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      PH_VALUE: begin
        acc_g    = eos_pkg::gather(acc, b, pos[1:0], big_endian);
        acc_next = acc_g;
        if (pos >= 4'd1) begin
          outcome = OC_FOUND;
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      default: begin
        outcome = OC_MISS;
      end
    endcase
  end

  // Decide now; on the final byte, treat the missing bytes as zero. Only a
  // pending value, or a little-endian entry whose count completes with zero
  // bytes, can still match.
  always_comb begin
    outcome_fin = outcome;
    value       = 16'd0;
    if (outcome == OC_FOUND) begin
      value = acc_g[15:0];
    end else if (outcome == OC_NONE && item.last_byte) begin
      outcome_fin = OC_MISS;
      if (phase_next == PH_VALUE) begin
        outcome_fin = OC_FOUND;
        if (pos_next != 4'd0) begin
          value = big_endian_next ? {acc_next[7:0], 8'h00} : {8'h00, acc_next[7:0]};
        end
      end else if (phase_next == PH_ENTRY && !big_endian_next && entry_matches_next) begin
        if (pos_next >= 4'd5 && pos_next <= 4'd7 && acc_next == eos_pkg::COUNT_ONE) begin
          outcome_fin = OC_FOUND;
        end
      end
    end
  end

  assign res_valid       = step && !decided && outcome_fin != OC_NONE;
  assign res.found       = (outcome_fin == OC_FOUND);
  assign res.orientation = value;
  assign res.in_range    = (outcome_fin == OC_FOUND) &&
                           value >= eos_pkg::ORIENT_MIN && value <= eos_pkg::ORIENT_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDENT;
      pos     <= 4'd0;
      decided <= 1'b0;
    end else if (step) begin
      if (item.last_byte) begin
        // rearm for the next marker
        phase   <= PH_IDENT;
        pos     <= 4'd0;
        decided <= 1'b0;
      end else if (!decided) begin
        phase            <= phase_next;
        pos              <= pos_next;
        big_endian       <= big_endian_next;
        first_order_byte <= first_order_byte_next;
        tags_left        <= tags_left_next;
        acc              <= acc_next;
        entry_matches    <= entry_matches_next;
        decided          <= (outcome != OC_NONE);
      end
    end
  end

endmodule

>>> rtl/core/eos_out_reg.sv
// Result register: holds one result beat until the consumer takes it.
module eos_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  eos_pkg::eos_result_t  res,
  output logic                  ready,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  found,
  output logic [15:0]           orientation,
  output logic                  in_range
);

  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      found       <= res.found;
      orientation <= res.orientation;
      in_range    <= res.in_range;
    end
  end

endmodule

>>> rtl/core/exif_orientation_scanner_unit.sv
// Path: input register, then the combinational scan, then the result register.
// Throughput: one byte per cycle unless a stalled result holds the input.
// Results: at most one per marker, on the deciding byte; the last byte rearms.
// The input stage accepts while a result waits, as long as the result register frees.
// Reset: synchronous, active high; clears both valid registers and rearms the scan.
module exif_orientation_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        found,
  output logic [15:0] orientation,
  output logic        in_range
);

  logic                 item_valid;
  eos_pkg::eos_item_t   item;
  logic                 out_ready;
  logic                 advance;
  logic                 res_valid;
  eos_pkg::eos_result_t res;

  assign advance = item_valid && out_ready;

  eos_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  eos_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  eos_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (res_valid),
    .res          (res),
    .ready        (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .orientation  (orientation),
    .in_range     (in_range)
  );

endmodule

>>> rtl/core/eos_checker.sv
// Port-level assertions for the scanner, bound to the top level.
module eos_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic        found,
  input logic [15:0] orientation,
  input logic        in_range
);

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(orientation) && $stable(found))
    else $error("result beat changed while stalled");

  // Input never stalls while the result register is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !byte_stall)
    else $error("input stalled with empty result register");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> orientation == 16'd0 && !in_range)
    else $error("not-found result carries a value");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && found |-> in_range == (orientation >= 16'd1 && orientation <= 16'd8))
    else $error("in_range flag disagrees with orientation");

endmodule

bind exif_orientation_scanner_unit eos_checker u_eos_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_stall   (byte_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .found        (found),
  .orientation  (orientation),
  .in_range     (in_range)
);

>>> bench/exif_orientation_scanner_unit_tb.sv
// Self-checking bench for the Exif orientation scanner: marker streams against a scan predictor.
`timescale 1ns / 100ps

module exif_orientation_scanner_unit_tb;

  localparam int          ITEMS        = 1400;
  localparam int          HANG_LIMIT   = 4000;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [47:0] EXIF_ID      = 48'h4578_6966_0000;

  typedef enum logic [2:0] {
    SC_IDENT, SC_ORDER, SC_MAGIC, SC_OFFSET, SC_COUNT, SC_ENTRY, SC_VALUE
  } scan_phase_t;

  typedef enum logic [1:0] {STEP_PENDING, STEP_MISS, STEP_FOUND} scan_step_t;

  class orientation_scoreboard;
    eos_pkg::eos_result_t pending_reports[$];
    int          mismatches;
    scan_phase_t phase;
    logic [3:0]  byte_idx;
    logic        big_end;
    logic [7:0]  first_mark;
    logic [15:0] tags_left;
    logic [31:0] acc;
    logic        entry_hit;
    logic        decided;

    function new();
      mismatches = 0;
      rearm();
    endfunction

    function void rearm();
      phase      = SC_IDENT;
      byte_idx   = 4'd0;
      big_end    = 1'b0;
      first_mark = 8'd0;
      tags_left  = 16'd0;
      acc        = 32'd0;
      entry_hit  = 1'b0;
      decided    = 1'b0;
    endfunction

    // Merge byte b as byte k of a multi-byte field in the current byte order
    function void fold_byte(input logic [7:0] b, input logic [3:0] k);
      if (k == 4'd0) acc = 32'd0;
      if (big_end) acc = {acc[23:0], b};
      else acc = acc | ({24'd0, b} << (8 * k[1:0]));
    endfunction

    function scan_step_t scan_byte(input logic [7:0] b);
      logic [3:0] p;
      p = byte_idx;
      case (phase)
        SC_IDENT: begin
          if (p > 4'd5 || b != EXIF_ID[47 - 8 * p -: 8]) return STEP_MISS;
          p++;
          if (p == 4'd6) begin
            phase = SC_ORDER;
            p = 4'd0;
          end
        end
        SC_ORDER: begin
          if (p == 4'd0) begin
            first_mark = b;
            p = 4'd1;
          end else begin
            if (first_mark == eos_pkg::ORDER_II && b == eos_pkg::ORDER_II) big_end = 1'b0;
            else if (first_mark == eos_pkg::ORDER_MM && b == eos_pkg::ORDER_MM) big_end = 1'b1;
            else return STEP_MISS;
            phase = SC_MAGIC;
            p = 4'd0;
          end
        end
        SC_MAGIC: begin
          fold_byte(b, p);
          p++;
          if (p >= 4'd2) begin
            if (acc != eos_pkg::TIFF_MAGIC) return STEP_MISS;
            phase = SC_OFFSET;
            p = 4'd0;
          end
        end
        SC_OFFSET: begin
          fold_byte(b, p);
          p++;
          if (p >= 4'd4) begin
            if (acc != eos_pkg::IFD_OFFSET) return STEP_MISS;
            phase = SC_COUNT;
            p = 4'd0;
          end
        end
        SC_COUNT: begin
          fold_byte(b, p);
          p++;
          if (p >= 4'd2) begin
            tags_left = acc[15:0];
            if (tags_left == 16'd0) return STEP_MISS;
            phase = SC_ENTRY;
            p = 4'd0;
          end
        end
        SC_ENTRY: begin
          if (p < 4'd2) fold_byte(b, p);
          else if (p < 4'd4) fold_byte(b, p - 4'd2);
          else if (p < 4'd8) fold_byte(b, p - 4'd4);
          if (p == 4'd1) entry_hit = (acc == eos_pkg::TAG_ORIENT);
          else if (p == 4'd3) entry_hit = entry_hit & (acc == eos_pkg::TYPE_SHORT);
          else if (p == 4'd7) begin
            entry_hit = entry_hit & (acc == eos_pkg::COUNT_ONE);
            if (entry_hit) begin
              phase = SC_VALUE;
              byte_idx = 4'd0;
              return STEP_PENDING;
            end
          end
          p++;
          // value bytes of a passed-over entry are skipped here
          if (p >= 4'd12) begin
            tags_left = tags_left - 16'd1;
            if (tags_left == 16'd0) return STEP_MISS;
            p = 4'd0;
          end
        end
        SC_VALUE: begin
          fold_byte(b, p);
          p++;
          if (p >= 4'd2) return STEP_FOUND;
        end
        default: return STEP_MISS;
      endcase
      byte_idx = p;
      return STEP_PENDING;
    endfunction

    function void note_byte(input logic [7:0] b, input logic l);
      scan_step_t           outcome;
      eos_pkg::eos_result_t rep;
      outcome = STEP_PENDING;
      if (!decided) begin
        outcome = scan_byte(b);
        // marker ended early: pad with zero bytes until the outcome is fixed
        if (outcome == STEP_PENDING && l) begin
          while (outcome == STEP_PENDING) begin
            if (phase == SC_ENTRY && byte_idx == 4'd0) outcome = STEP_MISS;
            else outcome = scan_byte(8'd0);
          end
        end
        if (outcome != STEP_PENDING) begin
          rep.found       = (outcome == STEP_FOUND);
          rep.orientation = rep.found ? acc[15:0] : 16'd0;
          rep.in_range    = rep.found && rep.orientation >= eos_pkg::ORIENT_MIN &&
                            rep.orientation <= eos_pkg::ORIENT_MAX;
          pending_reports.push_back(rep);
          decided = 1'b1;
        end
      end
      if (l) rearm();
    endfunction

    function void log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void check_report(input logic f, input logic [15:0] o, input logic r);
      eos_pkg::eos_result_t want;
      if (pending_reports.size() == 0) begin
        log_mismatch($sformatf("unexpected result found=%b orientation=%h in_range=%b",
                               f, o, r));
        return;
      end
      want = pending_reports.pop_front();
      if (f !== want.found || o !== want.orientation || r !== want.in_range)
        log_mismatch($sformatf("expected found=%b orientation=%h in_range=%b, got %b %h %b",
                               want.found, want.orientation, want.in_range, f, o, r));
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        byte_valid   = 1'b0;
  logic [7:0]  data_byte    = 8'd0;
  logic        last_byte    = 1'b0;
  logic        result_stall = 1'b0;
  logic        byte_stall;
  logic        result_valid;
  logic        found;
  logic [15:0] orientation;
  logic        in_range;

  logic        idling     = 1'b1;
  int          sent_bytes = 0;
  int          quiet_cycles = 0;
  logic [7:0]  marker_q[$];

  orientation_scoreboard sb = new();

  exif_orientation_scanner_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .orientation  (orientation),
    .in_range     (in_range)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    result_stall <= idling && ($urandom_range(99) < 30);
  end

  // Note accepted beats, check results, and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (byte_valid && !byte_stall) sb.note_byte(data_byte, last_byte);
      if (result_valid && !result_stall) sb.check_report(found, orientation, in_range);
      if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("exif_orientation_scanner_unit_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic void put16(input logic [15:0] v, input bit be);
    if (be) begin
      marker_q.push_back(v[15:8]);
      marker_q.push_back(v[7:0]);
    end else begin
      marker_q.push_back(v[7:0]);
      marker_q.push_back(v[15:8]);
    end
  endfunction

  function automatic void put32(input logic [31:0] v, input bit be);
    if (be) begin
      put16(v[31:16], be);
      put16(v[15:0], be);
    end else begin
      put16(v[15:0], be);
      put16(v[31:16], be);
    end
  endfunction

  function automatic void put_entry(input logic [15:0] tag, input logic [15:0] typ,
                                    input logic [31:0] cnt, input logic [15:0] v,
                                    input bit be);
    put16(tag, be);
    put16(typ, be);
    put32(cnt, be);
    put16(v, be);
    put16(16'($urandom), be);
  endfunction

  // Header, tag count field, and entries; the orientation entry sits at hit_at (-1: none)
  function automatic void build_exif(input bit be, input int tag_cnt, input int entries,
                                     input int hit_at, input logic [15:0] v);
    int i;
    marker_q.delete();
    for (i = 0; i < 6; i++) marker_q.push_back(EXIF_ID[47 - 8 * i -: 8]);
    marker_q.push_back(be ? eos_pkg::ORDER_MM : eos_pkg::ORDER_II);
    marker_q.push_back(be ? eos_pkg::ORDER_MM : eos_pkg::ORDER_II);
    put16(eos_pkg::TIFF_MAGIC[15:0], be);
    put32(eos_pkg::IFD_OFFSET, be);
    put16(16'(tag_cnt), be);
    for (i = 0; i < entries; i++) begin
      if (i == hit_at) begin
        put_entry(eos_pkg::TAG_ORIENT[15:0], eos_pkg::TYPE_SHORT[15:0], eos_pkg::COUNT_ONE,
                  v, be);
      end else begin
        case ($urandom_range(3))
          0: put_entry(16'($urandom), 16'($urandom), $urandom, 16'($urandom), be);
          1: put_entry(eos_pkg::TAG_ORIENT[15:0], 16'($urandom_range(4, 12)),
                       eos_pkg::COUNT_ONE, 16'($urandom_range(1, 8)), be);
          2: put_entry(eos_pkg::TAG_ORIENT[15:0], eos_pkg::TYPE_SHORT[15:0],
                       32'($urandom_range(2, 9)), 16'($urandom_range(1, 8)), be);
          default: put_entry(eos_pkg::TAG_ORIENT[15:0] ^ (16'd1 << $urandom_range(15)),
                             eos_pkg::TYPE_SHORT[15:0], eos_pkg::COUNT_ONE,
                             16'($urandom_range(1, 8)), be);
        endcase
      end
    end
  endfunction

  function automatic void cut_to(input int n);
    while (marker_q.size() > n) void'(marker_q.pop_back());
  endfunction

  function automatic void add_junk(input int n);
    int i;
    for (i = 0; i < n; i++) marker_q.push_back(8'($urandom));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l);
    while (idling && $urandom_range(99) < 30) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= l;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_marker();
    int i;
    for (i = 0; i < marker_q.size(); i++) send_byte(marker_q[i], i == marker_q.size() - 1);
    marker_q.delete();
  endtask

  initial begin : stimulus
    bit          be;
    int          entries;
    int          hit;
    int          cnt;
    int          pick;
    logic [15:0] v;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // found in both byte orders, at the range edges and outside
    build_exif(0, 1, 1, 0, 16'd1);      send_marker();
    build_exif(1, 2, 2, 1, 16'd8);      send_marker();
    build_exif(0, 3, 3, 2, 16'd9);      send_marker();
    build_exif(1, 1, 1, 0, 16'hFFFF);   send_marker();
    build_exif(0, 1, 1, 0, 16'd0);      send_marker();
    // decoy entries only, tag count runs out
    build_exif(1, 2, 2, -1, 16'd0);     send_marker();
    // orientation entry beyond the tag count
    build_exif(0, 1, 2, 1, 16'd4);      send_marker();
    // zero tag count, entry bytes after it are ignored
    build_exif(0, 0, 1, -1, 16'd0);     send_marker();
    // header mismatches: identifier, byte order, magic, offset
    build_exif(0, 1, 1, 0, 16'd3);      marker_q[0] = 8'h00;     send_marker();
    build_exif(1, 1, 1, 0, 16'd3);      marker_q[5] = 8'h01;     send_marker();
    build_exif(0, 1, 1, 0, 16'd3);      marker_q[7] = eos_pkg::ORDER_MM;  send_marker();
    build_exif(1, 1, 1, 0, 16'd3);      marker_q[6] = 8'h58;     send_marker();
    build_exif(0, 1, 1, 0, 16'd3);      marker_q[9] = 8'h01;     send_marker();
    build_exif(0, 1, 1, 0, 16'd3);      marker_q[10] = 8'h10;    send_marker();
    // marker ends early: in the identifier, on the count, inside an entry, inside the value
    build_exif(0, 1, 1, 0, 16'd5);      cut_to(3);  send_marker();
    build_exif(1, 1, 1, 0, 16'd5);      cut_to(16); send_marker();
    build_exif(0, 1, 1, 0, 16'd5);      cut_to(21); send_marker();
    build_exif(0, 5, 1, -1, 16'd0);     send_marker();
    build_exif(1, 1, 1, 0, 16'h0206);   cut_to(25); send_marker();
    // bytes after the decision, then a one-byte marker
    build_exif(1, 1, 1, 0, 16'd6);      add_junk(6); send_marker();
    marker_q.push_back(8'h45);          send_marker();

    while (sent_bytes < ITEMS) begin
      idling  <= !(sent_bytes >= 600 && sent_bytes < 900);
      pick    = $urandom_range(99);
      be      = $urandom_range(1);
      entries = $urandom_range(1, 4);
      hit     = $urandom_range(0, entries);
      if (hit == entries) hit = -1;
      case ($urandom_range(4))
        0, 1, 2: v = 16'($urandom_range(1, 8));
        3:       v = $urandom_range(1) ? 16'd0 : 16'($urandom_range(9, 20));
        default: v = 16'($urandom);
      endcase
      cnt = entries;
      if ($urandom_range(9) == 0) cnt = $urandom_range(0, 6);
      build_exif(be, cnt, entries, hit, v);
      if (pick < 15) begin
        marker_q[$urandom_range(marker_q.size() - 1)] ^= 8'(1 << $urandom_range(7));
      end else if (pick < 30) begin
        cut_to($urandom_range(1, marker_q.size()));
      end else if (pick < 40) begin
        marker_q.delete();
        if ($urandom_range(1)) marker_q.push_back(8'h45);
        add_junk($urandom_range(1, 12));
      end
      if ($urandom_range(9) < 2) add_junk($urandom_range(1, 6));
      send_marker();
    end

    byte_valid <= 1'b0;
    idling     <= 1'b1;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("exif_orientation_scanner_unit_tb OK");
    end else begin
      $display("exif_orientation_scanner_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/eos_pkg.sv
rtl/core/eos_in_reg.sv
rtl/core/eos_scan.sv
rtl/core/eos_out_reg.sv
rtl/core/exif_orientation_scanner_unit.sv
rtl/core/eos_checker.sv
bench/exif_orientation_scanner_unit_tb.sv
